// ===== rtl/core/wtri_pkg.sv =====
// Package with the opcodes, register indexes and fixed widths of the wavetable reader.
`default_nettype none

package wtri_pkg;

    // Item opcodes.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic {
        CFG_TABLE_LENGTH = 1'b0,
        CFG_INTERP_MODE  = 1'b1
    } t_cfg_index;

    // Interpolation modes.
    typedef enum logic {
        MODE_TRUNCATE = 1'b0,
        MODE_LINEAR   = 1'b1
    } t_interp_mode;

    // Fixed widths of the register and index fields.
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned INDEX_W = 32;

    // Register reset values.
    localparam logic [LEN_W-1:0] LEN_RESET  = 12'd4094;
    localparam t_interp_mode     MODE_RESET = MODE_LINEAR;

endpackage

`default_nettype wire

// ===== rtl/core/wavetable_read_interpolated.sv =====
// Top level of the wavetable reader with optional linear interpolation.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------------------
//  in        request    i_in_valid / o_in_ready   i_opcode, i_write_address,
//                                                 i_write_sample, i_read_index
//  out       result     o_out_valid / i_out_ready o_sample_out
//  cfg       write      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request is taken every cycle while o_in_ready is high. A read request passes through the
// memory read, the multiplier and the output add, each a registered stage, before its result
// appears. The table is split into an even and an odd bank so that both neighbouring entries
// come out of one read. Each stage moves on when the one after it is empty or moving, so a
// held result does not stop requests while the pipeline has a free slot. Reset clears only
// the valid bits and the configuration registers, not the table or the pipeline data.
`default_nettype none

module wavetable_read_interpolated #(
    parameter int unsigned TABLE_DEPTH  = 4096,
    parameter int unsigned FRAC_BITS    = 16,
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_opcode,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]   i_write_address,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   i_write_sample,
    input  wire logic signed [wtri_pkg::INDEX_W-1:0] i_read_index,
    // Result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    // Configuration port
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [wtri_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int unsigned BANK_AW    = ADDR_W - 1;
    localparam int unsigned BANK_DEPTH = 1 << BANK_AW;
    localparam int unsigned IPOS_W     = wtri_pkg::INDEX_W - 1 - FRAC_BITS;
    localparam int unsigned CMP_A      = (IPOS_W > wtri_pkg::LEN_W) ? IPOS_W : wtri_pkg::LEN_W;
    localparam int unsigned CMP_W      = (CMP_A > ADDR_W + 1) ? CMP_A : ADDR_W + 1;
    localparam int unsigned PROD_W     = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W:0]  DEPTH_V = (ADDR_W + 1)'(TABLE_DEPTH);

    // Configuration registers.
    logic [wtri_pkg::LEN_W-1:0] r_len;
    wtri_pkg::t_interp_mode     r_mode;

    // Pipeline registers.
    logic                           r_s1_vld;
    logic                           r_s1_hit;
    logic                           r_s1_swap;
    logic                           r_s1_lin;
    logic [FRAC_BITS-1:0]           r_s1_frac;
    logic                           r_s2_vld;
    logic                           r_s2_hit;
    logic signed [SAMPLE_WIDTH-1:0] r_s2_a;
    logic signed [PROD_W-1:0]       r_s2_prod;
    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;

    // Request decode.
    logic                     w_en_out;
    logic                     w_en_s2;
    logic                     w_en_s1;
    logic                     w_acc_wr;
    logic                     w_acc_rd;
    logic                     w_wr_ok;
    logic [CMP_W-1:0]         w_ipos;
    logic [CMP_W-1:0]         w_len;
    logic                     w_hit;
    logic [ADDR_W-1:0]        w_pos;
    logic [BANK_AW-1:0]       w_pos_half;
    logic [BANK_AW-1:0]       w_even_raddr;
    logic [SAMPLE_WIDTH-1:0]  w_rd_even;
    logic [SAMPLE_WIDTH-1:0]  w_rd_odd;

    // Datapath.
    logic signed [SAMPLE_WIDTH-1:0] w_a;
    logic signed [SAMPLE_WIDTH-1:0] w_b;
    logic signed [SAMPLE_WIDTH:0]   w_diff;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [PROD_W-1:0]       w_step;
    logic [SAMPLE_WIDTH-1:0]        w_sum;

    // Stage enables: a stage loads when it is empty or its contents move on.
    assign w_en_out   = !r_out_vld || i_out_ready;
    assign w_en_s2    = !r_s2_vld || w_en_out;
    assign w_en_s1    = !r_s1_vld || w_en_s2;
    assign o_in_ready = w_en_s1;

    assign w_acc_wr = i_in_valid && w_en_s1 && (i_opcode == wtri_pkg::OP_WRITE);
    assign w_acc_rd = i_in_valid && w_en_s1 && (i_opcode == wtri_pkg::OP_READ);
    assign w_wr_ok  = {1'b0, i_write_address} < DEPTH_V;

    // Range check on the integer part against the length in use.
    assign w_ipos = CMP_W'(i_read_index[wtri_pkg::INDEX_W-2:FRAC_BITS]);
    assign w_len  = (CMP_W'(r_len) > LEN_MAX) ? LEN_MAX : CMP_W'(r_len);
    assign w_hit  = !i_read_index[wtri_pkg::INDEX_W-1] && (w_ipos < w_len);

    // An odd position takes its lower entry from the odd bank and the next one from the even.
    assign w_pos        = w_ipos[ADDR_W-1:0];
    assign w_pos_half   = w_pos[ADDR_W-1:1];
    assign w_even_raddr = w_pos[0] ? w_pos_half + BANK_AW'(1) : w_pos_half;

    wtri_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BANK_DEPTH)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (w_acc_wr && w_wr_ok && !i_write_address[0]),
        .i_waddr (i_write_address[ADDR_W-1:1]),
        .i_wdata (i_write_sample),
        .i_re    (w_acc_rd),
        .i_raddr (w_even_raddr),
        .o_rdata (w_rd_even)
    );

    wtri_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (BANK_DEPTH)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (w_acc_wr && w_wr_ok && i_write_address[0]),
        .i_waddr (i_write_address[ADDR_W-1:1]),
        .i_wdata (i_write_sample),
        .i_re    (w_acc_rd),
        .i_raddr (w_pos_half),
        .o_rdata (w_rd_odd)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= wtri_pkg::LEN_RESET;
            r_mode <= wtri_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            case (wtri_pkg::t_cfg_index'(i_cfg_index))
                wtri_pkg::CFG_TABLE_LENGTH: begin
                    r_len <= i_cfg_data[wtri_pkg::LEN_W-1:0];
                end
                wtri_pkg::CFG_INTERP_MODE: begin
                    r_mode <= wtri_pkg::t_interp_mode'(i_cfg_data[0]);
                end
                default: begin
                    r_len <= r_len;
                end
            endcase
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en_s1) begin
                r_s1_vld <= w_acc_rd;
            end
            if (w_en_s2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_en_out) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    // Read stage: control that travels alongside the memory read. Truncate mode uses a zero
    // fraction and a zero difference, so the next entry has no bearing on the result.
    always_ff @(posedge i_clk) begin
        if (w_en_s1) begin
            r_s1_hit  <= w_hit;
            r_s1_swap <= w_pos[0];
            r_s1_lin  <= (r_mode == wtri_pkg::MODE_LINEAR);
            r_s1_frac <= (r_mode == wtri_pkg::MODE_LINEAR) ?
                         i_read_index[FRAC_BITS-1:0] : '0;
        end
    end

    // Multiply stage: difference of the neighbours times the fraction.
    assign w_a    = r_s1_swap ? w_rd_odd : w_rd_even;
    assign w_b    = r_s1_swap ? w_rd_even : w_rd_odd;
    assign w_diff = r_s1_lin ? ({w_b[SAMPLE_WIDTH-1], w_b} - {w_a[SAMPLE_WIDTH-1], w_a}) : '0;
    assign w_prod = w_diff * $signed({1'b0, r_s1_frac});

    always_ff @(posedge i_clk) begin
        if (w_en_s2) begin
            r_s2_hit  <= r_s1_hit;
            r_s2_a    <= w_a;
            r_s2_prod <= w_prod;
        end
    end

    // Output stage: floor of the scaled product added to the lower entry, or zero for a read out of
    // range; the sum always lies between the two entries, so the low bits are exact.
    assign w_step = r_s2_prod >>> FRAC_BITS;
    assign w_sum  = r_s2_a + w_step[SAMPLE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_sample <= r_s2_hit ? w_sum : '0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_sample;

endmodule

`default_nettype wire

// ===== rtl/core/wtri_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module wtri_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
